// ----- hdl/two_choice_run_placement_assert.svh -----
// assertion macros shared by the placement block
`ifndef TWO_CHOICE_RUN_PLACEMENT_ASSERT_SVH
`define TWO_CHOICE_RUN_PLACEMENT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TCRP_ASSERT_IMP(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TCRP_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hdl/tcrp_pkg.sv -----
`default_nettype none

package tcrp_pkg;

    // fixed field widths
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int RUN_W     = 16;
    localparam int HASH_W    = 32;
    localparam int START_W   = 10;
    localparam int COUNT_W   = 11;
    localparam int STASH_W   = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN   = 1'b1;

    // action codes
    localparam logic ACT_PLACE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET_VAL = 11'd1024;

    typedef struct packed {
        logic               action;
        logic [RUN_W-1:0]   run_length;
        logic [HASH_W-1:0]  first_hash;
        logic [HASH_W-1:0]  second_hash;
    } tcrp_in_t;

    typedef struct packed {
        logic [START_W-1:0] start_bin;
        logic [COUNT_W-1:0] placed_count;
        logic [COUNT_W-1:0] padded_count;
        logic [STASH_W-1:0] stash_count;
        logic               took_second;
    } tcrp_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_LIMIT,
        ST_CLAMP,
        ST_SHAPE,
        ST_SUPERS,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_ADDR,
        ST_SCAN,
        ST_PICK,
        ST_UPDATE,
        ST_FINISH
    } tcrp_state_t;

endpackage

`default_nettype wire

// ----- hdl/tcrp_fill_mem.sv -----
`default_nettype none

module tcrp_fill_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 16
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [DATA_W-1:0] rdata_a,
    output logic      [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge aclk) begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ----- hdl/tcrp_mod_unit.sv -----
`default_nettype none

module tcrp_mod_unit #(
    parameter int DIV_W = 11
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [tcrp_pkg::HASH_W-1:0] dividend_a,
    input  wire logic [tcrp_pkg::HASH_W-1:0] dividend_b,
    input  wire logic [DIV_W-1:0]            divisor,
    output logic                             done,
    output logic      [DIV_W-1:0]            rem_a,
    output logic      [DIV_W-1:0]            rem_b
);

    import tcrp_pkg::*;

    localparam int CNT_W = $clog2(HASH_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [HASH_W-1:0] dvd_a_reg, dvd_b_reg;
    logic [DIV_W-1:0] rem_a_reg, rem_b_reg;
    logic [DIV_W-1:0] rem_a_next, rem_b_next;
    logic [DIV_W-1:0] div_reg;
    logic [DIV_W:0]   trial_a, trial_b;

    // one restoring step per cycle on both lanes
    always_comb begin
        trial_a = {rem_a_reg, dvd_a_reg[HASH_W-1]};
        trial_b = {rem_b_reg, dvd_b_reg[HASH_W-1]};
        if (trial_a >= {1'b0, div_reg}) begin
            rem_a_next = DIV_W'(trial_a - {1'b0, div_reg});
        end else begin
            rem_a_next = DIV_W'(trial_a);
        end
        if (trial_b >= {1'b0, div_reg}) begin
            rem_b_next = DIV_W'(trial_b - {1'b0, div_reg});
        end else begin
            rem_b_next = DIV_W'(trial_b);
        end
    end

    // step counter and completion pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(HASH_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shift and partial remainders
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_a_reg <= dividend_a;
            dvd_b_reg <= dividend_b;
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            div_reg   <= divisor;
        end else if (busy_reg) begin
            dvd_a_reg <= dvd_a_reg << 1;
            dvd_b_reg <= dvd_b_reg << 1;
            rem_a_reg <= rem_a_next;
            rem_b_reg <= rem_b_next;
        end
    end

    assign done  = done_reg;
    assign rem_a = rem_a_reg;
    assign rem_b = rem_b_reg;

endmodule

`default_nettype wire

// ----- hdl/two_choice_run_placement.sv -----
// place: input transaction to m_valid runs through the 32-step remainder unit, then the scan
// and update passes at one bin per cycle, span = padded_count
// clear: one fill entry zeroed per cycle over all MAX_BINS entries; one item in flight,
// the next input transaction is taken only once the result is loaded into m_data
// reset: aresetn low clears control, bin_count and max_run go to 1024, then the fill memory
// is swept to zero with s_ready low (config writes still taken)
`default_nettype none

module two_choice_run_placement #(
    parameter int MAX_BINS   = 1024,
    parameter int FILL_WIDTH = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire tcrp_pkg::tcrp_in_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output tcrp_pkg::tcrp_out_t                 m_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tcrp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tcrp_pkg::CFG_W-1:0]     cfg_data
);

    import tcrp_pkg::*;

    `include "two_choice_run_placement_assert.svh"

    localparam int AW  = $clog2(MAX_BINS);
    localparam int CW  = AW + 1;
    localparam int CW1 = CW + 1;
    localparam int LW  = $clog2(AW + 1);
    localparam int SW  = FILL_WIDTH + AW;
    localparam logic [FILL_WIDTH-1:0] FILL_MAX = '1;

    tcrp_state_t state_reg, state_next;

    logic [CFG_W-1:0]      bin_count_reg, max_run_reg;
    tcrp_in_t              in_reg, in_next;
    logic [CW-1:0]         nb_reg, nb_next;
    logic [LW-1:0]         mr_log_reg, mr_log_next;
    logic [CW-1:0]         placed_reg, placed_next;
    logic [STASH_W-1:0]    stash_reg, stash_next;
    logic [LW-1:0]         span_log_reg, span_log_next;
    logic [CW-1:0]         span_reg, span_next;
    logic [CW-1:0]         supers_reg, supers_next;
    logic [AW-1:0]         s1_reg, s1_next, s2_reg, s2_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic                  inr_a_reg, inr_a_next, inr_b_reg, inr_b_next;
    logic [AW-1:0]         wptr_reg, wptr_next;
    logic [SW-1:0]         total_a_reg, total_a_next, total_b_reg, total_b_next;
    logic                  second_reg, second_next;
    logic [AW-1:0]         start_reg, start_next;
    logic [AW-1:0]         clr_idx_reg, clr_idx_next;
    logic                  clr_item_reg, clr_item_next;
    logic                  m_valid_reg, m_valid_next;
    tcrp_out_t             m_data_reg, m_data_next;

    logic                  s_accept, out_load, span_end;
    logic [CW-1:0]         nb_calc, mr_lim, mr_val, pm1;
    logic [LW-1:0]         mr_log_calc, hb, span_log_calc;
    logic [CW1-1:0]        sum_a, sum_b;
    logic                  in_a, in_b;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr_a, mem_raddr_b;
    logic [FILL_WIDTH-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

    logic                  mod_start, mod_done;
    logic [CW-1:0]         mod_rem_a, mod_rem_b;

    tcrp_fill_mem #(
        .DEPTH  (MAX_BINS),
        .ADDR_W (AW),
        .DATA_W (FILL_WIDTH)
    ) u_fill_mem (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    tcrp_mod_unit #(
        .DIV_W (CW)
    ) u_mod_unit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (mod_start),
        .dividend_a (in_reg.first_hash),
        .dividend_b (in_reg.second_hash),
        .divisor    (supers_reg),
        .done       (mod_done),
        .rem_a      (mod_rem_a),
        .rem_b      (mod_rem_b)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign s_accept  = s_valid && s_ready;
    assign out_load  = (state_reg == ST_FINISH) && (!m_valid_reg || m_ready);
    assign span_end  = (idx_reg == span_reg);

    // bins in use, clamped to 1..MAX_BINS
    always_comb begin
        if (bin_count_reg == '0) begin
            nb_calc = CW'(1);
        end else if (int'(bin_count_reg) > MAX_BINS) begin
            nb_calc = CW'(MAX_BINS);
        end else begin
            nb_calc = CW'(bin_count_reg);
        end
    end

    // usable max run, rounded down to a power of two
    always_comb begin
        if (max_run_reg == '0) begin
            mr_lim = CW'(1);
        end else if (int'(max_run_reg) > int'(nb_reg)) begin
            mr_lim = nb_reg;
        end else begin
            mr_lim = CW'(max_run_reg);
        end
        mr_log_calc = '0;
        for (int i = 0; i < CW; i++) begin
            if (mr_lim[i]) begin
                mr_log_calc = LW'(i);
            end
        end
    end

    assign mr_val = CW'(1) << mr_log_reg;

    // span exponent: smallest power of two not below the placed count, capped at the max run
    always_comb begin
        pm1 = placed_reg - CW'(1);
        hb  = '0;
        for (int i = 0; i < CW; i++) begin
            if (pm1[i]) begin
                hb = LW'(i + 1);
            end
        end
        if (placed_reg <= CW'(1)) begin
            span_log_calc = '0;
        end else if (hb > mr_log_reg) begin
            span_log_calc = mr_log_reg;
        end else begin
            span_log_calc = hb;
        end
    end

    // bin addresses for the scan and update passes
    always_comb begin
        if (state_reg == ST_UPDATE) begin
            sum_a = CW1'(start_reg) + CW1'(idx_reg);
        end else begin
            sum_a = CW1'(s1_reg) + CW1'(idx_reg);
        end
        sum_b = CW1'(s2_reg) + CW1'(idx_reg);
        in_a  = sum_a < CW1'(nb_reg);
        in_b  = sum_b < CW1'(nb_reg);
        mem_raddr_a = in_a ? AW'(sum_a) : '0;
        mem_raddr_b = in_b ? AW'(sum_b) : '0;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == AW'(MAX_BINS - 1)) begin
                    state_next = clr_item_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_data.action == ACT_CLEAR) ? ST_CLEAR : ST_SETUP;
                end
            end
            ST_SETUP:    state_next = ST_LIMIT;
            ST_LIMIT:    state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_SHAPE;
            ST_SHAPE:    state_next = ST_SUPERS;
            ST_SUPERS:   state_next = ST_MOD_GO;
            ST_MOD_GO:   state_next = ST_MOD_WAIT;
            ST_MOD_WAIT: begin
                if (mod_done) begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:     state_next = ST_SCAN;
            ST_SCAN: begin
                if (span_end && !pend_reg) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:     state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (span_end && !pend_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        in_next       = in_reg;
        nb_next       = nb_reg;
        mr_log_next   = mr_log_reg;
        placed_next   = placed_reg;
        stash_next    = stash_reg;
        span_log_next = span_log_reg;
        span_next     = span_reg;
        supers_next   = supers_reg;
        s1_next       = s1_reg;
        s2_next       = s2_reg;
        idx_next      = idx_reg;
        pend_next     = 1'b0;
        inr_a_next    = inr_a_reg;
        inr_b_next    = inr_b_reg;
        wptr_next     = wptr_reg;
        total_a_next  = total_a_reg;
        total_b_next  = total_b_reg;
        second_next   = second_reg;
        start_next    = start_reg;
        clr_idx_next  = clr_idx_reg;
        clr_item_next = clr_item_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = wptr_reg;
        mem_wdata     = '0;
        mod_start     = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + AW'(1);
            end
            ST_IDLE: begin
                if (s_accept) begin
                    in_next       = s_data;
                    clr_idx_next  = '0;
                    clr_item_next = (s_data.action == ACT_CLEAR);
                end
            end
            ST_SETUP: begin
                nb_next = nb_calc;
            end
            ST_LIMIT: begin
                mr_log_next = mr_log_calc;
            end
            ST_CLAMP: begin
                if (int'(in_reg.run_length) > int'(mr_val)) begin
                    placed_next = mr_val;
                    stash_next  = STASH_W'(int'(in_reg.run_length) - int'(mr_val));
                end else begin
                    placed_next = CW'(in_reg.run_length);
                    stash_next  = '0;
                end
            end
            ST_SHAPE: begin
                span_log_next = span_log_calc;
                span_next     = CW'(1) << span_log_calc;
            end
            ST_SUPERS: begin
                supers_next = CW'((CW1'(nb_reg) + CW1'(span_reg) - CW1'(1)) >> span_log_reg);
            end
            ST_MOD_GO: begin
                mod_start = 1'b1;
            end
            ST_ADDR: begin
                s1_next      = AW'(CW1'(mod_rem_a) << span_log_reg);
                s2_next      = AW'(CW1'(mod_rem_b) << span_log_reg);
                idx_next     = '0;
                total_a_next = '0;
                total_b_next = '0;
            end
            ST_SCAN: begin
                // issue both candidate reads, accumulate in the next cycle
                if (!span_end) begin
                    idx_next   = idx_reg + CW'(1);
                    pend_next  = 1'b1;
                    inr_a_next = in_a;
                    inr_b_next = in_b;
                end
                if (pend_reg) begin
                    if (inr_a_reg) begin
                        total_a_next = total_a_reg + SW'(mem_rdata_a);
                    end
                    if (inr_b_reg) begin
                        total_b_next = total_b_reg + SW'(mem_rdata_b);
                    end
                end
            end
            ST_PICK: begin
                // tie keeps the first candidate
                second_next = (total_a_reg > total_b_reg);
                start_next  = (total_a_reg > total_b_reg) ? s2_reg : s1_reg;
                idx_next    = '0;
            end
            ST_UPDATE: begin
                // read bin, write back incremented next cycle; bins in a span never repeat
                if (!span_end) begin
                    idx_next   = idx_reg + CW'(1);
                    pend_next  = 1'b1;
                    inr_a_next = in_a;
                    wptr_next  = mem_raddr_a;
                end
                if (pend_reg && inr_a_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = wptr_reg;
                    mem_wdata = (mem_rdata_a == FILL_MAX) ? mem_rdata_a
                                                          : mem_rdata_a + FILL_WIDTH'(1);
                end
            end
            ST_FINISH: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    if (clr_item_reg) begin
                        m_data_next = '0;
                    end else begin
                        m_data_next.start_bin    = START_W'(start_reg);
                        m_data_next.placed_count = COUNT_W'(placed_reg);
                        m_data_next.padded_count = COUNT_W'(span_reg);
                        m_data_next.stash_count  = stash_reg;
                        m_data_next.took_second  = second_reg;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            clr_item_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            bin_count_reg <= CFG_RESET_VAL;
            max_run_reg   <= CFG_RESET_VAL;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            clr_item_reg <= clr_item_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BIN_COUNT: bin_count_reg <= cfg_data;
                    REG_MAX_RUN:   max_run_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        in_reg       <= in_next;
        nb_reg       <= nb_next;
        mr_log_reg   <= mr_log_next;
        placed_reg   <= placed_next;
        stash_reg    <= stash_next;
        span_log_reg <= span_log_next;
        span_reg     <= span_next;
        supers_reg   <= supers_next;
        s1_reg       <= s1_next;
        s2_reg       <= s2_next;
        idx_reg      <= idx_next;
        inr_a_reg    <= inr_a_next;
        inr_b_reg    <= inr_b_next;
        wptr_reg     <= wptr_next;
        total_a_reg  <= total_a_next;
        total_b_reg  <= total_b_next;
        second_reg   <= second_next;
        start_reg    <= start_next;
        m_data_reg   <= m_data_next;
    end

    // checks
    `TCRP_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "second transaction taken while busy")
    `TCRP_ASSERT_IMP(a_rem_range, aclk, aresetn, mod_done, (mod_rem_a < supers_reg) && (mod_rem_b < supers_reg), "remainder not below superbin count")
    `TCRP_ASSERT_IMP(a_start_range, aclk, aresetn, state_reg == ST_UPDATE, CW'(start_reg) < nb_reg, "chosen span starts outside used bins")
    `TCRP_ASSERT_IMP(a_no_write_scan, aclk, aresetn, state_reg == ST_SCAN, !mem_we, "fill memory written during scan")

endmodule

`default_nettype wire
